// ===== rtl/wpm_pkg.sv =====
// shared types and constants of the wildcard pattern matcher
`timescale 1ns / 1ps

package wpm_pkg;

  localparam int PATTERN_MAX = 128;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_WORD   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // control broadcast to every cell
  typedef struct packed {
    logic       fresh;
    logic       feed;
    logic       shift;
    logic       clear;
    logic [7:0] chr;
  } ctrl_t;

  // token info handed from a cell to its right neighbor
  typedef struct packed {
    logic occ;
    logic star;
    logic first;
    logic fwd;
    logic pre;
  } tok_t;

  // pattern data handed from a cell to its left neighbor on append
  typedef struct packed {
    logic [7:0] chr;
    logic       occ;
  } shift_t;

  typedef struct packed {
    logic matched;
    logic ovf;
  } result_t;

endpackage

// ===== rtl/wpm_cell.sv =====
// one pattern position: stored byte, occupancy and active bit
`timescale 1ns / 1ps

module wpm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wpm_pkg::ctrl_t  ctrl_i,
  input  wpm_pkg::tok_t   left_i,
  input  wpm_pkg::shift_t right_i,
  output wpm_pkg::tok_t   tok_o,
  output wpm_pkg::shift_t shf_o
);

  logic [7:0] chr_q, chr_d;
  logic       occ_q, occ_d;
  logic       act_q, act_d;
  logic       star, first, start, eff, fwd, pre, nxt;

  assign star  = occ_q && (chr_q == wpm_pkg::STAR_CHAR);
  assign first = occ_q && !left_i.occ;
  // leading star of the pattern also opens the position after it
  assign start = first || (left_i.first && left_i.star);
  assign eff   = ctrl_i.fresh ? start : act_q;
  assign fwd   = eff && occ_q && !star &&
                 ((chr_q == wpm_pkg::ANY_CHAR) || (chr_q == ctrl_i.chr));
  assign pre   = (eff && star) || left_i.fwd;
  // star runs are collapsed on load, so closure is a single hop
  assign nxt   = pre || (left_i.pre && left_i.star);

  assign tok_o = '{occ: occ_q, star: star, first: first, fwd: fwd, pre: pre};
  assign shf_o = '{chr: chr_q, occ: occ_q};

  always_comb begin
    occ_d = occ_q;
    chr_d = chr_q;
    act_d = act_q;
    if (ctrl_i.clear) begin
      occ_d = 1'b0;
    end else if (ctrl_i.shift) begin
      occ_d = right_i.occ;
      chr_d = right_i.chr;
    end
    if (ctrl_i.feed) begin
      act_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      act_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
  end

endmodule

// ===== rtl/wpm_out.sv =====
// result register toward the receiver
`timescale 1ns / 1ps

module wpm_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wpm_pkg::result_t res_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output wpm_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  wpm_pkg::result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/wildcard_pattern_match.sv =====
// top level of the wildcard pattern matcher
// Usage: each input request carries an opcode and a byte. Clear empties the
// pattern and the overflow flag, append adds a pattern byte ('*' any run,
// '?' any one byte), word char advances the current word, word end gives
// one result request with matched and pattern_overflowed.
// The pattern sits right-aligned in a row of cells; an append shifts the row
// one cell to the left. Repeated stars are stored once, so star closure is a
// single hop and each byte updates the whole active set.
// Throughput: one request per cycle, every opcode, while no word end is held
// back by a result that waits under out_stall_i.
// Latency: the result of a word end is valid the cycle after its request is
// accepted and stays until taken.
// Stall: while a result waits under out_stall_i, only a further word end is
// stalled; clear, append and word chars keep flowing.
// Reset: empty pattern, overflow clear, no result pending, word at start.
`timescale 1ns / 1ps

module wildcard_pattern_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] char_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflowed_o
);

  localparam int N = wpm_pkg::PATTERN_MAX;

  wpm_pkg::tok_t    tok [N+1];
  wpm_pkg::shift_t  shf [N+1];
  wpm_pkg::ctrl_t   ctrl;
  wpm_pkg::result_t res_in, res_out;
  wpm_pkg::op_e     op;

  logic [N-1:0]              occ_vec;
  logic [wpm_pkg::LEN_W-1:0] raw_len_q, raw_len_d;
  logic                      ovf_q, ovf_d;
  logic                      fresh_q, fresh_d;
  logic                      acc_q, acc_d;
  logic                      in_acc, room, collapse;
  logic                      first_a, start_a, eff_a, nxt_a;
  logic                      load;

  assign op     = wpm_pkg::op_e'(opcode_i);
  assign in_stall_o = out_valid_o && out_stall_i && (op == wpm_pkg::OP_END);
  assign in_acc = in_valid_i && !in_stall_o;
  assign room   = raw_len_q < wpm_pkg::LEN_W'(N);
  // a star after a star adds nothing to the language
  assign collapse = (char_value_i == wpm_pkg::STAR_CHAR) && tok[N].star;

  assign tok[0] = '0;
  assign shf[N] = '{chr: char_value_i, occ: 1'b1};

  always_comb begin
    ctrl       = '0;
    ctrl.fresh = fresh_q;
    ctrl.chr   = char_value_i;
    raw_len_d  = raw_len_q;
    ovf_d      = ovf_q;
    fresh_d    = fresh_q;
    acc_d      = acc_q;
    load       = 1'b0;
    if (in_acc) begin
      case (op)
        wpm_pkg::OP_CLEAR: begin
          ctrl.clear = 1'b1;
          raw_len_d  = '0;
          ovf_d      = 1'b0;
          fresh_d    = 1'b1;
        end
        wpm_pkg::OP_APPEND: begin
          if (room) begin
            raw_len_d  = raw_len_q + 1'b1;
            ctrl.shift = !collapse;
          end else begin
            ovf_d = 1'b1;
          end
          fresh_d = 1'b1;
        end
        wpm_pkg::OP_WORD: begin
          ctrl.feed = 1'b1;
          acc_d     = nxt_a;
          fresh_d   = 1'b0;
        end
        wpm_pkg::OP_END: begin
          load    = 1'b1;
          fresh_d = 1'b1;
        end
        default: begin
          fresh_d = fresh_q;
        end
      endcase
    end
  end

  for (genvar p = 0; p < N; p++) begin : g_cell
    wpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (tok[p]),
      .right_i (shf[p+1]),
      .tok_o   (tok[p+1]),
      .shf_o   (shf[p])
    );
    assign occ_vec[p] = shf[p].occ;
  end

  // end-of-pattern position, always present right of the last cell
  assign first_a = !occ_vec[N-1];
  assign start_a = first_a || (tok[N].first && tok[N].star);
  assign eff_a   = fresh_q ? start_a : acc_q;
  assign nxt_a   = tok[N].fwd || (tok[N].pre && tok[N].star);

  assign res_in = '{matched: eff_a, ovf: ovf_q};

  wpm_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res_in),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign matched_o            = res_out.matched;
  assign pattern_overflowed_o = res_out.ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_len_q <= '0;
      ovf_q     <= 1'b0;
      fresh_q   <= 1'b1;
      acc_q     <= 1'b0;
    end else begin
      raw_len_q <= raw_len_d;
      ovf_q     <= ovf_d;
      fresh_q   <= fresh_d;
      acc_q     <= acc_d;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == wpm_pkg::OP_END)) |=> out_valid_o)
    else $error("word end produced no result");

  a_occ_right_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_vec & ~{1'b1, occ_vec[N-1:1]}) == '0)
    else $error("pattern cells not right-aligned");

  a_occ_within_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) <= int'(raw_len_q))
    else $error("more cells occupied than bytes appended");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (raw_len_q == wpm_pkg::LEN_W'(N)))
    else $error("overflow flag set with room left");
`endif

endmodule
